>>> design/epsc_pkg.sv
// ----------------------------------------------------------------------------
// epsc_pkg
// Shared types, constants and the control store for the epoch seconds to
// calendar converter.
// ----------------------------------------------------------------------------
package epsc_pkg;

   localparam int unsigned EPOCH_W   = 32;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned YEAR_W    = 12;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned DAY_W     = 5;

   localparam int unsigned STEP_W    = 4;
   localparam int unsigned OP_W      = 4;
   localparam int unsigned COND_W    = 2;

   // Seconds of the day stay below 86400, minutes of the day below 1440.
   localparam int unsigned SOD_W     = 17;
   localparam int unsigned MOD_W     = 11;
   localparam int unsigned DAYS_W    = 16;
   localparam int unsigned LEN_W     = 9;
   localparam int unsigned M100_W    = 7;
   localparam int unsigned M400_W    = 9;

   // Shared multiplier operand and product widths.
   localparam int unsigned MUL_W     = 26;
   localparam int unsigned PROD_W    = 2 * MUL_W;

   // Divisions by constants are reciprocal multiplications. Days are the
   // seconds shifted down by seven, times the reciprocal of 675, shifted down
   // by 35. Minutes of the day are the seconds of the day shifted down by two,
   // times the reciprocal of 15, shifted down by 19. Hours are the minutes of
   // the day times the reciprocal of 60, shifted down by 18. Each is exact over
   // the whole range of its operand.
   localparam int unsigned DAY_PRE    = 7;
   localparam int unsigned DAY_SHIFT  = 35;
   localparam int unsigned MIN_PRE    = 2;
   localparam int unsigned MIN_SHIFT  = 19;
   localparam int unsigned HOUR_SHIFT = 18;

   localparam logic [MUL_W-1:0]  DAY_RECIP     = MUL_W'(50903317);
   localparam logic [MUL_W-1:0]  MIN_RECIP     = MUL_W'(34953);
   localparam logic [MUL_W-1:0]  HOUR_RECIP    = MUL_W'(4370);
   localparam logic [MUL_W-1:0]  SECS_PER_DAY  = MUL_W'(86400);
   localparam logic [MUL_W-1:0]  MINS_PER_HOUR = MUL_W'(60);

   localparam logic [YEAR_W-1:0] BASE_YEAR    = YEAR_W'(1970);
   localparam logic [M100_W-1:0] BASE_M100    = M100_W'(70);
   localparam logic [M400_W-1:0] BASE_M400    = M400_W'(370);
   localparam logic [M100_W-1:0] LAST_M100    = M100_W'(99);
   localparam logic [M400_W-1:0] LAST_M400    = M400_W'(399);
   localparam logic [LEN_W-1:0]  YEAR_DAYS    = LEN_W'(365);
   localparam logic [LEN_W-1:0]  LEAP_DAYS    = LEN_W'(366);

   // Datapath operations.
   localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
   localparam logic [OP_W-1:0] OP_DAYS   = 4'd2;
   localparam logic [OP_W-1:0] OP_SOD    = 4'd3;
   localparam logic [OP_W-1:0] OP_MOD    = 4'd4;
   localparam logic [OP_W-1:0] OP_HOUR   = 4'd5;
   localparam logic [OP_W-1:0] OP_MINUTE = 4'd6;
   localparam logic [OP_W-1:0] OP_SETYR  = 4'd7;
   localparam logic [OP_W-1:0] OP_YEAR   = 4'd8;
   localparam logic [OP_W-1:0] OP_SETMON = 4'd9;
   localparam logic [OP_W-1:0] OP_MONTH  = 4'd10;
   localparam logic [OP_W-1:0] OP_EMIT   = 4'd11;

   // Sequencing conditions.
   localparam logic [COND_W-1:0] COND_START = 2'd0;
   localparam logic [COND_W-1:0] COND_NEXT  = 2'd1;
   localparam logic [COND_W-1:0] COND_FIT   = 2'd2;
   localparam logic [COND_W-1:0] COND_JUMP  = 2'd3;

   // Program steps.
   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DAYS    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SOD     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MOD     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HOUR    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MINUTE  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SETYR   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_YEAR    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SETMON  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_MONTH   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd10;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: COND_JUMP, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE:   w = '{OP_LOAD,   COND_START, STEP_DAYS};
         STEP_DAYS:   w = '{OP_DAYS,   COND_NEXT,  STEP_IDLE};
         STEP_SOD:    w = '{OP_SOD,    COND_NEXT,  STEP_IDLE};
         STEP_MOD:    w = '{OP_MOD,    COND_NEXT,  STEP_IDLE};
         STEP_HOUR:   w = '{OP_HOUR,   COND_NEXT,  STEP_IDLE};
         STEP_MINUTE: w = '{OP_MINUTE, COND_NEXT,  STEP_IDLE};
         STEP_SETYR:  w = '{OP_SETYR,  COND_NEXT,  STEP_IDLE};
         STEP_YEAR:   w = '{OP_YEAR,   COND_FIT,   STEP_SETMON};
         STEP_SETMON: w = '{OP_SETMON, COND_NEXT,  STEP_IDLE};
         STEP_MONTH:  w = '{OP_MONTH,  COND_FIT,   STEP_EMIT};
         STEP_EMIT:   w = '{OP_EMIT,   COND_JUMP,  STEP_IDLE};
         default:     w = '{OP_NOP,    COND_JUMP,  STEP_IDLE};
      endcase
      return w;
   endfunction

   // Month lengths, February given as 29 days in a leap year and 28 otherwise.
   function automatic logic [LEN_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic            leap);
      logic [LEN_W-1:0] len;
      len = LEN_W'(31);
      unique case (month)
         4'd2:    len = leap ? LEN_W'(29) : LEN_W'(28);
         4'd4:    len = LEN_W'(30);
         4'd6:    len = LEN_W'(30);
         4'd9:    len = LEN_W'(30);
         4'd11:   len = LEN_W'(30);
         default: len = LEN_W'(31);
      endcase
      return len;
   endfunction

endpackage

>>> design/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts a 32-bit count of Unix seconds into hour, minute and the
// Gregorian year, month and day, under control of a small microprogram.
// ----------------------------------------------------------------------------
// The conversion time grows with the number of whole years past 1970 and with
// the month; the year walk, one year per cycle, sets most of it. A new request
// is taken only in the idle step, so a conversion ends before the next begins:
// busy stays high through the result cycle and drops only in the idle step.
// The receiver cannot stall: the strobe lasts one cycle.
// Reset (synchronous, active high) returns the sequencer to its idle step.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit
   import epsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [EPOCH_W-1:0]  req_epoch_seconds,
   output logic                rsp_valid,
   output logic [HOUR_W-1:0]   rsp_hour_of_day,
   output logic [MINUTE_W-1:0] rsp_minute_of_hour,
   output logic [YEAR_W-1:0]   rsp_calendar_year,
   output logic [MONTH_W-1:0]  rsp_calendar_month,
   output logic [DAY_W-1:0]    rsp_day_of_month
);

   // Sequencer state: the step counter.
   logic [STEP_W-1:0]   pc_ff, pc_in;

   // Datapath registers.
   logic [EPOCH_W-1:0]  secs_ff, secs_in;
   logic [SOD_W-1:0]    sod_ff, sod_in;
   logic [MOD_W-1:0]    mod_ff, mod_in;
   logic [DAYS_W-1:0]   days_ff, days_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [M100_W-1:0]   m100_ff, m100_in;
   logic [M400_W-1:0]   m400_ff, m400_in;
   logic [MONTH_W-1:0]  month_ff, month_in;
   logic [DAY_W-1:0]    day_ff, day_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;

   ctrl_word_type       ctrl;
   logic                accept;
   logic                leap;
   logic [LEN_W-1:0]    span_len;
   logic                fit;
   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [PROD_W-1:0]   prod;

   // The control word for the current step is read straight from the store.
   assign ctrl   = ucode_rom(pc_ff);
   assign busy   = (pc_ff != STEP_IDLE);
   assign accept = start && !busy;

   // Leap rule kept through running remainders, so no division by 100 or 400
   // is ever needed: the low two year bits give the remainder by four.
   assign leap = ((year_ff[1:0] == 2'd0) && (m100_ff != '0)) || (m400_ff == '0);

   // The length being compared against is the year or the current month.
   assign span_len = (ctrl.op == OP_YEAR) ? (leap ? LEAP_DAYS : YEAR_DAYS)
                                          : month_days(month_ff, leap);
   assign fit      = (days_ff < DAYS_W'(span_len));

   // One multiplier is shared by the steps that split the timestamp. Each step
   // picks its operands; the divisions by constants become reciprocal products.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.op)
         OP_DAYS: begin
            mul_a = MUL_W'(secs_ff[EPOCH_W-1:DAY_PRE]);
            mul_b = DAY_RECIP;
         end
         OP_SOD: begin
            mul_a = MUL_W'(days_ff);
            mul_b = SECS_PER_DAY;
         end
         OP_MOD: begin
            mul_a = MUL_W'(sod_ff[SOD_W-1:MIN_PRE]);
            mul_b = MIN_RECIP;
         end
         OP_HOUR: begin
            mul_a = MUL_W'(mod_ff);
            mul_b = HOUR_RECIP;
         end
         OP_MINUTE: begin
            mul_a = MUL_W'(hour_ff);
            mul_b = MINS_PER_HOUR;
         end
         default: begin
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Step sequencing.
   always_comb begin
      pc_in = pc_ff;
      unique case (ctrl.cond)
         COND_START: pc_in = start ? ctrl.target : pc_ff;
         COND_NEXT:  pc_in = pc_ff + STEP_W'(1);
         COND_FIT:   pc_in = fit ? ctrl.target : pc_ff;
         COND_JUMP:  pc_in = ctrl.target;
         default:    pc_in = STEP_IDLE;
      endcase
   end

   // Datapath, driven by the operation field of the control word.
   always_comb begin
      secs_in   = secs_ff;
      sod_in    = sod_ff;
      mod_in    = mod_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      m100_in   = m100_ff;
      m400_in   = m400_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            if (accept) begin
               secs_in = req_epoch_seconds;
            end
         end
         OP_DAYS: begin
            days_in = prod[DAY_SHIFT +: DAYS_W];
         end
         OP_SOD: begin
            // The seconds of the day are below 2^17, so the low bits suffice.
            sod_in = secs_ff[SOD_W-1:0] - prod[SOD_W-1:0];
         end
         OP_MOD: begin
            mod_in = prod[MIN_SHIFT +: MOD_W];
         end
         OP_HOUR: begin
            hour_in = prod[HOUR_SHIFT +: HOUR_W];
         end
         OP_MINUTE: begin
            minute_in = mod_ff[MINUTE_W-1:0] - prod[MINUTE_W-1:0];
         end
         OP_SETYR: begin
            year_in = BASE_YEAR;
            m100_in = BASE_M100;
            m400_in = BASE_M400;
         end
         OP_YEAR: begin
            if (!fit) begin
               days_in = days_ff - DAYS_W'(span_len);
               year_in = year_ff + YEAR_W'(1);
               m100_in = (m100_ff == LAST_M100) ? '0 : (m100_ff + M100_W'(1));
               m400_in = (m400_ff == LAST_M400) ? '0 : (m400_ff + M400_W'(1));
            end
         end
         OP_SETMON: begin
            month_in = MONTH_W'(1);
         end
         OP_MONTH: begin
            if (fit) begin
               day_in = days_ff[DAY_W-1:0] + DAY_W'(1);
            end else begin
               days_in  = days_ff - DAYS_W'(span_len);
               month_in = month_ff + MONTH_W'(1);
            end
         end
         OP_EMIT: begin
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      secs_ff   <= secs_in;
      sod_ff    <= sod_in;
      mod_ff    <= mod_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      m100_ff   <= m100_in;
      m400_ff   <= m400_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
   end

   // The result is shown during the single emit step.
   assign rsp_valid          = (ctrl.op == OP_EMIT);
   assign rsp_hour_of_day    = hour_ff;
   assign rsp_minute_of_hour = minute_ff;
   assign rsp_calendar_year  = year_ff;
   assign rsp_calendar_month = month_ff;
   assign rsp_day_of_month   = day_ff;

   // After the result transfer the block is free again.
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy still high after the result transfer");

   // An accepted request occupies the block on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // A result carries a time of day and a calendar date in range.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour_of_day < HOUR_W'(24)) && (rsp_minute_of_hour < MINUTE_W'(60))
                    && (rsp_calendar_month != '0) && (rsp_calendar_month < MONTH_W'(13))
                    && (rsp_day_of_month != '0))
      else $error("result field out of range");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the epoch seconds to calendar converter. A short
// table of hand-picked timestamps (epoch, minute, day, month, year and leap
// boundaries, both ends of the 32-bit range) runs first, followed by random
// timestamps biased towards calendar boundaries. Every result is compared
// field by field against hand-written values or a behavioural predictor.
// ----------------------------------------------------------------------------
module tb_top
   import epsc_pkg::*;
();

   // Slowest conversion time; the end-of-run drain allows a margin on top.
   localparam int unsigned WORST_LATENCY = 155;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned RANDOM_ITEMS  = 825;
   localparam int unsigned SECS_IN_MIN   = 60;
   localparam int unsigned SECS_IN_HOUR  = 3600;
   localparam int unsigned SECS_IN_DAY   = 86400;
   localparam int unsigned FIRST_YEAR    = 1970;
   localparam int unsigned LAST_YEAR     = 2106;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
   } civil_time_type;

   // One row of the directed table. Where known is set, the expected date
   // and time are written out by hand; otherwise the predictor supplies them.
   typedef struct {
      logic [EPOCH_W-1:0] secs;
      bit                 known;
      civil_time_type     typed;
   } timestamp_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [EPOCH_W-1:0]  req_epoch_seconds = '0;
   logic                busy;
   logic                rsp_valid;
   logic [HOUR_W-1:0]   rsp_hour_of_day;
   logic [MINUTE_W-1:0] rsp_minute_of_hour;
   logic [YEAR_W-1:0]   rsp_calendar_year;
   logic [MONTH_W-1:0]  rsp_calendar_month;
   logic [DAY_W-1:0]    rsp_day_of_month;

   // Dates still owed by the converter, oldest first.
   civil_time_type pending_dates[$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;

   epoch_seconds_to_calendar_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_epoch_seconds  (req_epoch_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_hour_of_day    (rsp_hour_of_day),
      .rsp_minute_of_hour (rsp_minute_of_hour),
      .rsp_calendar_year  (rsp_calendar_year),
      .rsp_calendar_month (rsp_calendar_month),
      .rsp_day_of_month   (rsp_day_of_month)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Calendar helpers and the predictor.
   // ------------------------------------------------------------------------

   // Full Gregorian rule: every fourth year, except centuries not divisible
   // by four hundred.
   function automatic bit is_leap_year(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned yr,
                                                input int unsigned mo);
      case (mo)
         2:            return is_leap_year(yr) ? 29 : 28;
         4, 6, 9, 11:  return 30;
         default:      return 31;
      endcase
   endfunction

   // Splits a timestamp into time of day, then walks whole years from 1970
   // and whole months within the final year. Seconds within the minute are
   // simply dropped.
   function automatic civil_time_type civil_of_epoch(input logic [EPOCH_W-1:0] secs);
      civil_time_type c;
      int unsigned    days;
      int unsigned    yr;
      int unsigned    mo;
      c.hour   = HOUR_W'((secs / SECS_IN_HOUR) % 24);
      c.minute = MINUTE_W'((secs / SECS_IN_MIN) % 60);
      days = secs / SECS_IN_DAY;
      yr   = FIRST_YEAR;
      while (days >= (is_leap_year(yr) ? 366 : 365)) begin
         days -= is_leap_year(yr) ? 366 : 365;
         yr++;
      end
      mo = 1;
      while (days >= month_length(yr, mo)) begin
         days -= month_length(yr, mo);
         mo++;
      end
      c.year  = YEAR_W'(yr);
      c.month = MONTH_W'(mo);
      c.day   = DAY_W'(days + 1);
      return c;
   endfunction

   function automatic civil_time_type civil(input int unsigned hr, input int unsigned mi,
                                            input int unsigned yr, input int unsigned mo,
                                            input int unsigned dy);
      civil_time_type c;
      c.hour   = HOUR_W'(hr);
      c.minute = MINUTE_W'(mi);
      c.year   = YEAR_W'(yr);
      c.month  = MONTH_W'(mo);
      c.day    = DAY_W'(dy);
      return c;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus generation.
   // ------------------------------------------------------------------------

   // A timestamp within two minutes of the start or end of the first or last
   // day of a random month. This is where the year and month walks are most
   // likely to be off by one. Dates beyond the 32-bit range are folded back
   // to just below the top.
   function automatic logic [EPOCH_W-1:0] near_date_boundary();
      int unsigned     yr;
      int unsigned     mo;
      int unsigned     dy;
      int unsigned     sod;
      longint unsigned days;
      longint unsigned total;
      yr  = $urandom_range(FIRST_YEAR, LAST_YEAR);
      mo  = $urandom_range(1, 12);
      dy  = ($urandom_range(0, 1) == 0) ? 1 : month_length(yr, mo);
      sod = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 119)
                                        : $urandom_range(SECS_IN_DAY - 120, SECS_IN_DAY - 1);
      days = 0;
      for (int unsigned y = FIRST_YEAR; y < yr; y++)
         days += is_leap_year(y) ? 366 : 365;
      for (int unsigned m = 1; m < mo; m++)
         days += month_length(yr, m);
      days += dy - 1;
      total = days * SECS_IN_DAY + sod;
      if (total > 64'hFFFF_FFFF)
         total = 64'hFFFF_FFFF - $urandom_range(0, SECS_IN_DAY);
      return total[EPOCH_W-1:0];
   endfunction

   // Roughly a third fully random, two fifths on calendar boundaries, a tenth
   // near each end of the range, and a tenth with a random top byte and low bits.
   function automatic logic [EPOCH_W-1:0] random_epoch();
      case ($urandom_range(0, 9))
         0, 1, 2:    return $urandom();
         3, 4, 5, 6: return near_date_boundary();
         7:          return $urandom_range(0, 3 * SECS_IN_DAY);
         8:          return 32'hFFFF_FFFF - $urandom_range(0, 60 * SECS_IN_DAY);
         default:    return {8'($urandom_range(0, 255)), 24'h0}
                            | ($urandom() & 32'h00FF_FFFF);
      endcase
   endfunction

   // Idle cycles before the next transfer is offered. Most gaps are short,
   // a few are long enough to straddle a whole conversion, and every fifth
   // run of forty items goes back to back with no idling at all.
   function automatic int unsigned pick_gap(input int unsigned idx);
      int unsigned r;
      if ((idx / 40) % 5 == 2)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 4);
      else if (r < 97)
         return $urandom_range(5, 30);
      else
         return $urandom_range(40, WORST_LATENCY + 20);
   endfunction

   // Offers one timestamp and returns at the edge that accepts it. While
   // start is low the data lines carry noise, which the block must ignore.
   // The expected date is queued at the accepting edge; the result comes back
   // only after the conversion steps, so there is no race with the checker.
   task automatic offer_timestamp(input logic [EPOCH_W-1:0] secs, input bit known,
                                  input civil_time_type typed, input int unsigned idx);
      int unsigned gap;
      gap = pick_gap(idx);
      if (gap != 0) begin
         start             <= 1'b0;
         req_epoch_seconds <= $urandom();
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (busy);
      pending_dates.push_back(known ? typed : civil_of_epoch(secs));
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // Result checking. Outputs are sampled at the edge that ends the strobe
   // cycle, before the block updates them, so the comparison never depends
   // on scheduling order within the time step.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      civil_time_type want;
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result with no transfer outstanding (year)",
                            rsp_calendar_year, 0);
         end else begin
            want = pending_dates.pop_front();
            if (rsp_hour_of_day !== want.hour)
               report_mismatch("hour_of_day", rsp_hour_of_day, want.hour);
            if (rsp_minute_of_hour !== want.minute)
               report_mismatch("minute_of_hour", rsp_minute_of_hour, want.minute);
            if (rsp_calendar_year !== want.year)
               report_mismatch("calendar_year", rsp_calendar_year, want.year);
            if (rsp_calendar_month !== want.month)
               report_mismatch("calendar_month", rsp_calendar_month, want.month);
            if (rsp_day_of_month !== want.day)
               report_mismatch("day_of_month", rsp_day_of_month, want.day);
         end
      end
   end

   // A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed table, random timestamps, drain.
   // ------------------------------------------------------------------------
   initial begin
      timestamp_row_type rows[$];
      civil_time_type    unused;
      unused = '0;

      // Known answers sit on the edges: the epoch itself, minute, hour, day,
      // month and year roll-overs, the last day of a leap year, the signed
      // 32-bit wrap point and the largest unsigned value. The other rows (a leap
      // day, century years with and without one, the second after the wrap, the
      // last second of 2105, alternating bit patterns) lean on the predictor.
      rows.push_back('{32'd0,          1'b1, civil( 0,  0, 1970,  1,  1)});
      rows.push_back('{32'd59,         1'b1, civil( 0,  0, 1970,  1,  1)});
      rows.push_back('{32'd60,         1'b1, civil( 0,  1, 1970,  1,  1)});
      rows.push_back('{32'd3599,       1'b1, civil( 0, 59, 1970,  1,  1)});
      rows.push_back('{32'd3600,       1'b1, civil( 1,  0, 1970,  1,  1)});
      rows.push_back('{32'd86399,      1'b1, civil(23, 59, 1970,  1,  1)});
      rows.push_back('{32'd86400,      1'b1, civil( 0,  0, 1970,  1,  2)});
      rows.push_back('{32'd2678399,    1'b1, civil(23, 59, 1970,  1, 31)});
      rows.push_back('{32'd2678400,    1'b1, civil( 0,  0, 1970,  2,  1)});
      rows.push_back('{32'd31535999,   1'b1, civil(23, 59, 1970, 12, 31)});
      rows.push_back('{32'd31536000,   1'b1, civil( 0,  0, 1971,  1,  1)});
      rows.push_back('{32'd68169600,   1'b0, unused});
      rows.push_back('{32'd94608000,   1'b1, civil( 0,  0, 1972, 12, 31)});
      rows.push_back('{32'd94694399,   1'b1, civil(23, 59, 1972, 12, 31)});
      rows.push_back('{32'd94694400,   1'b1, civil( 0,  0, 1973,  1,  1)});
      rows.push_back('{32'd951782400,  1'b0, unused});
      rows.push_back('{32'd978220800,  1'b0, unused});
      rows.push_back('{32'd2147483647, 1'b1, civil( 3, 14, 2038,  1, 19)});
      rows.push_back('{32'd2147483648, 1'b0, unused});
      rows.push_back('{32'd4107456000, 1'b0, unused});
      rows.push_back('{32'd4107542400, 1'b0, unused});
      rows.push_back('{32'd4291747199, 1'b0, unused});
      rows.push_back('{32'hFFFF_FFFF,  1'b1, civil( 6, 28, 2106,  2,  7)});
      rows.push_back('{32'hAAAA_AAAA,  1'b0, unused});
      rows.push_back('{32'h5555_5555,  1'b0, unused});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         offer_timestamp(rows[i].secs, rows[i].known, rows[i].typed, i);
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
         offer_timestamp(random_epoch(), 1'b0, unused, rows.size() + n);
      start <= 1'b0;

      // Let every outstanding result arrive, then watch a little longer for
      // any stray strobe.
      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (WORST_LATENCY + 16) @(posedge clock);

      if (mismatches == 0 && pending_dates.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
